### design/psfu_pkg.sv
// ============================================================================
// psfu_pkg
// shared constants and control types for the proportional switch flow update
// ============================================================================
`default_nettype none

package psfu_pkg;

    localparam int MAX_PATHS = 16;
    localparam int ADDR_W    = $clog2(MAX_PATHS);
    localparam int CNT_W     = $clog2(MAX_PATHS + 1);

    localparam int FLOW_W  = 31;
    localparam int COST_W  = 32;
    localparam int STEP_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int CHG_W   = 32;
    localparam int TOTAL_W = 40;

    localparam int ENTRY_W = FLOW_W + COST_W;
    localparam int DIFF_W  = COST_W + 1;
    localparam int PROD_W  = FLOW_W + COST_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int ACC_W   = TERM_W + $clog2(MAX_PATHS) + 1;
    localparam int MAG_W   = TERM_W + 1;
    localparam int SCALE_W = MAG_W + STEP_W;

    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(655);
    localparam logic [ACC_W-1:0]   SUM_LIM    = ACC_W'(1) << (MAG_W - 1);
    localparam logic [MAG_W-1:0]   CHG_NEG_LIM = MAG_W'(1) << (CHG_W - 1);
    localparam logic [MAG_W-1:0]   CHG_POS_LIM = (MAG_W'(1) << (CHG_W - 1)) - MAG_W'(1);
    localparam logic [FLOW_W-1:0]  FLOW_MAX   = {FLOW_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] waddr;
        logic              rd_i;
        logic              rd_pair;
        logic [ADDR_W-1:0] raddr;
        logic              acc_clr;
        logic              clamp;
        logic              scale;
        logic              sat;
        logic              emit;
        logic              last;
        logic              clr_total;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### design/proportional_switch_flow_update.sv
// ============================================================================
// proportional_switch_flow_update
// proportional switch flow adjustment for one demand group at a time
// ============================================================================
// Input beats (s_*) carry one path's flow and cost; they are buffered until a
// beat with s_end_of_group, up to 16 paths per group (extra paths are dropped).
// Each buffered path then yields one result beat (m_*) in arrival order: new
// flow, flow change and the running total of |change| for the round, with
// m_last_of_group on the group's last path. The total clears after a group
// whose closing beat had s_end_of_round set.
// Collection accepts one beat per cycle. Once a group closes, s_ready stays low
// while the group is processed: every path walks all n buffered paths through
// one shared pair multiplier, as the buffer's single read port serialises the
// pair reads. A result waits in the output register while m_ready is low,
// which stalls the sequencer; after the last result is loaded s_ready rises
// again.
// cfg_wr_en/cfg_wr_data write the 16-bit step size (reset 655).
// aresetn is synchronous, active low; it empties the buffer, clears the total
// and restores the step size.
// ============================================================================
`default_nettype none

module proportional_switch_flow_update (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [psfu_pkg::STEP_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [psfu_pkg::FLOW_W-1:0]   s_path_flow,
    input  wire logic [psfu_pkg::COST_W-1:0]   s_path_cost,
    input  wire logic                          s_end_of_group,
    input  wire logic                          s_end_of_round,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [psfu_pkg::FLOW_W-1:0]        m_new_flow,
    output logic [psfu_pkg::CHG_W-1:0]         m_flow_change,
    output logic                               m_last_of_group,
    output logic [psfu_pkg::TOTAL_W-1:0]       m_total_change
);

    psfu_pkg::cmd_t cmd;
    psfu_pkg::sts_t sts;

    psfu_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_end_of_group (s_end_of_group),
        .s_end_of_round (s_end_of_round),
        .sts            (sts),
        .cmd            (cmd)
    );

    psfu_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_path_flow     (s_path_flow),
        .s_path_cost     (s_path_cost),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_flow      (m_new_flow),
        .m_flow_change   (m_flow_change),
        .m_last_of_group (m_last_of_group),
        .m_total_change  (m_total_change)
    );

endmodule

`default_nettype wire

### design/psfu_ram.sv
// ============================================================================
// psfu_ram
// generic single write port, single read port ram with registered read data
// ============================================================================
`default_nettype none

module psfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/psfu_ctrl.sv
// ============================================================================
// psfu_ctrl
// sequencer: buffers a group, then walks every path over all pairs and emits
// ============================================================================
`default_nettype none

module psfu_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_end_of_group,
    input  wire logic           s_end_of_round,
    input  wire psfu_pkg::sts_t sts,
    output psfu_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_PAIRS,
        ST_DRAIN,
        ST_CLAMP,
        ST_SCALE,
        ST_SAT,
        ST_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    logic [psfu_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [psfu_pkg::ADDR_W-1:0]      i_reg, i_next;
    logic [psfu_pkg::ADDR_W-1:0]      j_reg, j_next;
    logic                             eor_reg, eor_next;
    logic [psfu_pkg::CNT_W-1:0]       last_idx;
    logic                             last_i;
    logic                             last_j;

    assign last_idx = count_reg - psfu_pkg::CNT_W'(1);
    assign last_i   = ({1'b0, i_reg} == last_idx);
    assign last_j   = ({1'b0, j_reg} == last_idx);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        eor_next   = eor_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (count_reg < psfu_pkg::CNT_W'(psfu_pkg::MAX_PATHS)) begin
                        cmd.wr     = 1'b1;
                        cmd.waddr  = count_reg[psfu_pkg::ADDR_W-1:0];
                        count_next = count_reg + psfu_pkg::CNT_W'(1);
                    end
                    if (s_end_of_group) begin
                        eor_next   = s_end_of_round;
                        i_next     = '0;
                        state_next = ST_RD_I;
                    end
                end
            end
            ST_RD_I: begin
                cmd.rd_i    = 1'b1;
                cmd.raddr   = i_reg;
                cmd.acc_clr = 1'b1;
                j_next      = '0;
                state_next  = ST_PAIRS;
            end
            ST_PAIRS: begin
                cmd.rd_pair = 1'b1;
                cmd.raddr   = j_reg;
                if (last_j) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + psfu_pkg::ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.last      = last_i;
                    cmd.clr_total = last_i && eor_reg;
                    if (last_i) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + psfu_pkg::ADDR_W'(1);
                        state_next = ST_RD_I;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            eor_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            eor_reg   <= eor_next;
        end
    end

    // buffer never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= psfu_pkg::CNT_W'(psfu_pkg::MAX_PATHS))
        else $error("group count above buffer depth");

    // pair reads stay inside the buffered entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAIRS) |-> ({1'b0, j_reg} < count_reg))
        else $error("pair read beyond buffered paths");

    // a result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register occupied");

endmodule

`default_nettype wire

### design/psfu_dp.sv
// ============================================================================
// psfu_dp
// datapath: path buffer, pairwise term pipeline, accumulator, step scaling,
// saturation, running total and output register
// ============================================================================
`default_nettype none

module psfu_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [psfu_pkg::STEP_W-1:0]   cfg_wr_data,
    input  wire logic [psfu_pkg::FLOW_W-1:0]   s_path_flow,
    input  wire logic [psfu_pkg::COST_W-1:0]   s_path_cost,
    input  wire psfu_pkg::cmd_t                cmd,
    output psfu_pkg::sts_t                     sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [psfu_pkg::FLOW_W-1:0]        m_new_flow,
    output logic [psfu_pkg::CHG_W-1:0]         m_flow_change,
    output logic                               m_last_of_group,
    output logic [psfu_pkg::TOTAL_W-1:0]       m_total_change
);

    // path buffer
    logic [psfu_pkg::ENTRY_W-1:0] ram_rdata;
    logic [psfu_pkg::FLOW_W-1:0]  rd_flow;
    logic [psfu_pkg::COST_W-1:0]  rd_cost;

    psfu_ram #(
        .WIDTH (psfu_pkg::ENTRY_W),
        .DEPTH (psfu_pkg::MAX_PATHS)
    ) u_buf (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (cmd.waddr),
        .wdata ({s_path_flow, s_path_cost}),
        .re    (cmd.rd_i | cmd.rd_pair),
        .raddr (cmd.raddr),
        .rdata (ram_rdata)
    );

    assign rd_flow = ram_rdata[psfu_pkg::ENTRY_W-1:psfu_pkg::COST_W];
    assign rd_cost = ram_rdata[psfu_pkg::COST_W-1:0];

    // control registers
    logic                          rdi_reg, rdp_reg, s1_valid_reg, s2_valid_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [psfu_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [psfu_pkg::STEP_W-1:0]   step_reg;

    // payload registers
    logic [psfu_pkg::FLOW_W-1:0]   fi_reg;
    logic [psfu_pkg::COST_W-1:0]   ci_reg;
    logic [psfu_pkg::FLOW_W-1:0]   s1_flow_reg, s1_flow_next;
    logic [psfu_pkg::COST_W-1:0]   s1_mag_reg, s1_mag_next;
    logic                          s1_neg_reg, s1_neg_next;
    logic [psfu_pkg::TERM_W-1:0]   s2_term_reg;
    logic                          s2_neg_reg;
    logic [psfu_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [psfu_pkg::MAG_W-1:0]    mag_reg, mag_next;
    logic                          neg_reg;
    logic [psfu_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic [psfu_pkg::CHG_W-1:0]    absv_reg, absv_next;
    logic [psfu_pkg::FLOW_W-1:0]   m_new_flow_reg, nf_next;
    logic [psfu_pkg::CHG_W-1:0]    m_flow_change_reg, chg_next;
    logic                          m_last_reg;
    logic [psfu_pkg::TOTAL_W-1:0]  m_total_reg, sat_total;

    logic [psfu_pkg::DIFF_W-1:0]   ci_ext, cj_ext, d_up, d_dn;
    logic [psfu_pkg::PROD_W-1:0]   pair_prod;
    logic [psfu_pkg::ACC_W-1:0]    term_ext, abs_acc;
    logic [psfu_pkg::MAG_W-1:0]    v_mag;
    logic [psfu_pkg::DIFF_W-1:0]   nf_a, nf_b, nf_sum;
    logic [psfu_pkg::TOTAL_W:0]    total_sum;

    // stage 1: cost difference and operand select
    always_comb begin
        ci_ext = {ci_reg[psfu_pkg::COST_W-1], ci_reg};
        cj_ext = {rd_cost[psfu_pkg::COST_W-1], rd_cost};
        d_up   = cj_ext - ci_ext;
        d_dn   = ci_ext - cj_ext;
        if (d_up[psfu_pkg::DIFF_W-1]) begin
            s1_flow_next = fi_reg;
            s1_mag_next  = d_dn[psfu_pkg::COST_W-1:0];
            s1_neg_next  = 1'b1;
        end else begin
            s1_flow_next = rd_flow;
            s1_mag_next  = d_up[psfu_pkg::COST_W-1:0];
            s1_neg_next  = 1'b0;
        end
    end

    // stage 2: pair product, stage 3: accumulate
    assign pair_prod = {{psfu_pkg::COST_W{1'b0}}, s1_flow_reg}
                     * {{psfu_pkg::FLOW_W{1'b0}}, s1_mag_reg};
    assign term_ext  = psfu_pkg::ACC_W'(s2_term_reg);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_clr) begin
            acc_next = '0;
        end else if (s2_valid_reg) begin
            acc_next = s2_neg_reg ? acc_reg - term_ext : acc_reg + term_ext;
        end
    end

    // clamp, scale by step, saturate
    assign abs_acc    = acc_reg[psfu_pkg::ACC_W-1] ? (~acc_reg + psfu_pkg::ACC_W'(1)) : acc_reg;
    assign mag_next   = (abs_acc > psfu_pkg::SUM_LIM) ? psfu_pkg::SUM_LIM[psfu_pkg::MAG_W-1:0]
                                                      : abs_acc[psfu_pkg::MAG_W-1:0];
    assign scale_next = {{psfu_pkg::STEP_W{1'b0}}, mag_reg}
                      * {{psfu_pkg::MAG_W{1'b0}}, step_reg};
    assign v_mag      = scale_reg[psfu_pkg::SCALE_W-1:psfu_pkg::FRAC_W];

    always_comb begin
        if (neg_reg) begin
            absv_next = (v_mag > psfu_pkg::CHG_NEG_LIM) ? psfu_pkg::CHG_NEG_LIM[psfu_pkg::CHG_W-1:0]
                                                        : v_mag[psfu_pkg::CHG_W-1:0];
        end else begin
            absv_next = (v_mag > psfu_pkg::CHG_POS_LIM) ? psfu_pkg::CHG_POS_LIM[psfu_pkg::CHG_W-1:0]
                                                        : v_mag[psfu_pkg::CHG_W-1:0];
        end
    end

    // new flow, signed change and running total
    always_comb begin
        nf_a = {2'b00, fi_reg};
        nf_b = {1'b0, absv_reg};
        if (neg_reg) begin
            nf_sum   = nf_a - nf_b;
            nf_next  = nf_sum[psfu_pkg::DIFF_W-1] ? '0 : nf_sum[psfu_pkg::FLOW_W-1:0];
            chg_next = ~absv_reg + psfu_pkg::CHG_W'(1);
        end else begin
            nf_sum   = nf_a + nf_b;
            nf_next  = (nf_sum[psfu_pkg::DIFF_W-1] | nf_sum[psfu_pkg::DIFF_W-2])
                       ? psfu_pkg::FLOW_MAX : nf_sum[psfu_pkg::FLOW_W-1:0];
            chg_next = absv_reg;
        end
        total_sum = {1'b0, total_reg} + (psfu_pkg::TOTAL_W + 1)'(absv_reg);
        sat_total = total_sum[psfu_pkg::TOTAL_W] ? psfu_pkg::TOTAL_MAX
                                                 : total_sum[psfu_pkg::TOTAL_W-1:0];
        total_next = total_reg;
        if (cmd.emit) begin
            total_next = cmd.clr_total ? '0 : sat_total;
        end
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdi_reg      <= 1'b0;
            rdp_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            total_reg    <= '0;
            step_reg     <= psfu_pkg::STEP_RESET;
        end else begin
            rdi_reg      <= cmd.rd_i;
            rdp_reg      <= cmd.rd_pair;
            s1_valid_reg <= rdp_reg;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= m_valid_next;
            total_reg    <= total_next;
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdi_reg) begin
            fi_reg <= rd_flow;
            ci_reg <= rd_cost;
        end
        s1_flow_reg <= s1_flow_next;
        s1_mag_reg  <= s1_mag_next;
        s1_neg_reg  <= s1_neg_next;
        s2_term_reg <= pair_prod[psfu_pkg::PROD_W-1:psfu_pkg::FRAC_W];
        s2_neg_reg  <= s1_neg_reg;
        acc_reg     <= acc_next;
        if (cmd.clamp) begin
            mag_reg <= mag_next;
            neg_reg <= acc_reg[psfu_pkg::ACC_W-1];
        end
        if (cmd.scale) begin
            scale_reg <= scale_next;
        end
        if (cmd.sat) begin
            absv_reg <= absv_next;
        end
        if (cmd.emit) begin
            m_new_flow_reg    <= nf_next;
            m_flow_change_reg <= chg_next;
            m_last_reg        <= cmd.last;
            m_total_reg       <= sat_total;
        end
    end

    assign sts.busy        = rdp_reg | s1_valid_reg | s2_valid_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_new_flow      = m_new_flow_reg;
    assign m_flow_change   = m_flow_change_reg;
    assign m_last_of_group = m_last_reg;
    assign m_total_change  = m_total_reg;

    // a new path never starts while pair terms are still in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_clr |-> !sts.busy)
        else $error("accumulator cleared with terms in flight");

    // end of round leaves the running total cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.clr_total) |=> (total_reg == '0))
        else $error("round total not cleared after end of round");

endmodule

`default_nettype wire

### dv/testbench.sv
// ============================================================================
// testbench
// self-checking bench for the proportional switch flow update block
// ============================================================================
// Path beats go in as groups of demand paths. A scoreboard predicts every
// group's updated flows, changes and round totals in 64-bit arithmetic. Each
// result beat is checked in order against that prediction. A short directed
// part covers saturation, single-path groups, equal costs, ignored round
// marks and buffer overflow. Random groups then run at several step sizes,
// with random gaps and stalls on both channels.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        CLK_PERIOD     = 10;
    localparam int        RESET_CYCLES   = 11;
    localparam int        MAX_GAP        = 13;
    localparam int        SETTLE_CYCLES  = 40;
    localparam int        WATCHDOG_LIMIT = 5000;
    localparam int        PHASE_BEATS    = 15;
    localparam longint    SUM_CLAMP      = longint'(1) << 47;
    localparam bit [63:0] CHANGE_POS_MAG = 64'h0000_0000_7FFF_FFFF;
    localparam bit [63:0] CHANGE_NEG_MAG = 64'h0000_0000_8000_0000;

    typedef struct {
        logic [psfu_pkg::FLOW_W-1:0]  new_flow;
        logic [psfu_pkg::CHG_W-1:0]   flow_change;
        logic                         last_of_group;
        logic [psfu_pkg::TOTAL_W-1:0] total_change;
    } path_update_t;

    class flow_update_scoreboard;
        logic [psfu_pkg::STEP_W-1:0]        step_q16;
        logic [psfu_pkg::FLOW_W-1:0]        group_flow [psfu_pkg::MAX_PATHS];
        logic signed [psfu_pkg::COST_W-1:0] group_cost [psfu_pkg::MAX_PATHS];
        int                                 group_len;
        longint                             round_sum;
        path_update_t                       pending_updates [$];
        int                                 errors;

        function new();
            step_q16  = psfu_pkg::STEP_RESET;
            group_len = 0;
            round_sum = 0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        function longint pair_term(logic [psfu_pkg::FLOW_W-1:0] fi,
                                   logic signed [psfu_pkg::COST_W-1:0] ci,
                                   logic [psfu_pkg::FLOW_W-1:0] fj,
                                   logic signed [psfu_pkg::COST_W-1:0] cj);
            longint    diff;
            bit [63:0] prod;
            diff = longint'(cj) - longint'(ci);
            if (diff > 0) begin
                prod = 64'(fj) * 64'(diff);
                return longint'(prod >> psfu_pkg::FRAC_W);
            end
            if (diff < 0) begin
                prod = 64'(fi) * 64'(-diff);
                return -longint'(prod >> psfu_pkg::FRAC_W);
            end
            return 0;
        endfunction

        function longint path_change(int i);
            longint    sum;
            bit [63:0] mag;
            bit [63:0] scaled;
            sum = 0;
            for (int j = 0; j < group_len; j++) begin
                sum += pair_term(group_flow[i], group_cost[i], group_flow[j], group_cost[j]);
            end
            if (sum > SUM_CLAMP) sum = SUM_CLAMP;
            if (sum < -SUM_CLAMP) sum = -SUM_CLAMP;
            mag    = (sum < 0) ? 64'(-sum) : 64'(sum);
            scaled = (mag * 64'(step_q16)) >> psfu_pkg::FRAC_W;
            if (sum < 0) begin
                return (scaled > CHANGE_NEG_MAG) ? -longint'(CHANGE_NEG_MAG) : -longint'(scaled);
            end
            return (scaled > CHANGE_POS_MAG) ? longint'(CHANGE_POS_MAG) : longint'(scaled);
        endfunction

        function void note_path(logic [psfu_pkg::FLOW_W-1:0] flow,
                                logic [psfu_pkg::COST_W-1:0] cost,
                                bit eog, bit eor);
            longint       change;
            longint       flow_next;
            path_update_t upd;
            if (group_len < psfu_pkg::MAX_PATHS) begin
                group_flow[group_len] = flow;
                group_cost[group_len] = cost;
                group_len++;
            end
            if (!eog) return;
            for (int i = 0; i < group_len; i++) begin
                change    = path_change(i);
                flow_next = longint'(group_flow[i]) + change;
                if (flow_next < 0) flow_next = 0;
                if (flow_next > longint'(psfu_pkg::FLOW_MAX)) begin
                    flow_next = longint'(psfu_pkg::FLOW_MAX);
                end
                round_sum += (change < 0) ? -change : change;
                if (round_sum > longint'(psfu_pkg::TOTAL_MAX)) begin
                    round_sum = longint'(psfu_pkg::TOTAL_MAX);
                end
                upd.new_flow      = flow_next[psfu_pkg::FLOW_W-1:0];
                upd.flow_change   = change[psfu_pkg::CHG_W-1:0];
                upd.last_of_group = (i == group_len - 1);
                upd.total_change  = round_sum[psfu_pkg::TOTAL_W-1:0];
                pending_updates.push_back(upd);
            end
            group_len = 0;
            if (eor) round_sum = 0;
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
            end
        endtask

        task check_result(path_update_t seen);
            path_update_t want;
            if (pending_updates.size() == 0) begin
                report("result beat with no update pending");
                return;
            end
            want = pending_updates.pop_front();
            compare_field("new_flow", 64'(seen.new_flow), 64'(want.new_flow));
            compare_field("flow_change", 64'(seen.flow_change), 64'(want.flow_change));
            compare_field("last_of_group", 64'(seen.last_of_group), 64'(want.last_of_group));
            compare_field("total_change", 64'(seen.total_change), 64'(want.total_change));
        endtask

        function int outstanding();
            return pending_updates.size();
        endfunction
    endclass

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_wr_en       = 1'b0;
    logic [psfu_pkg::STEP_W-1:0]   cfg_wr_data     = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [psfu_pkg::FLOW_W-1:0]   s_path_flow     = '0;
    logic [psfu_pkg::COST_W-1:0]   s_path_cost     = '0;
    logic                          s_end_of_group  = 1'b0;
    logic                          s_end_of_round  = 1'b0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [psfu_pkg::FLOW_W-1:0]   m_new_flow;
    logic [psfu_pkg::CHG_W-1:0]    m_flow_change;
    logic                          m_last_of_group;
    logic [psfu_pkg::TOTAL_W-1:0]  m_total_change;

    bit                            steady          = 1'b0;
    int                            quiet_cycles    = 0;
    logic [psfu_pkg::STEP_W-1:0]   step_plan [5]   = '{16'hFFFF, 16'h0000, 16'h0001,
                                                       16'h8000, 16'h0000};

    flow_update_scoreboard updates_sb = new();

    proportional_switch_flow_update i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_path_flow     (s_path_flow),
        .s_path_cost     (s_path_cost),
        .s_end_of_group  (s_end_of_group),
        .s_end_of_round  (s_end_of_round),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_flow      (m_new_flow),
        .m_flow_change   (m_flow_change),
        .m_last_of_group (m_last_of_group),
        .m_total_change  (m_total_change)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [psfu_pkg::FLOW_W-1:0] draw_flow();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return psfu_pkg::FLOW_MAX;
            2: return psfu_pkg::FLOW_W'($urandom_range(0, 32'h0010_0000));
            default: return psfu_pkg::FLOW_W'($urandom);
        endcase
    endfunction

    function automatic logic [psfu_pkg::COST_W-1:0] draw_cost();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return psfu_pkg::COST_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return psfu_pkg::COST_W'($urandom);
        endcase
    endfunction

    task automatic push_path(input logic [psfu_pkg::FLOW_W-1:0] flow,
                             input logic [psfu_pkg::COST_W-1:0] cost,
                             input bit eog, input bit eor, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_path_flow    <= flow;
        s_path_cost    <= cost;
        s_end_of_group <= eog;
        s_end_of_round <= eor;
        do @(posedge aclk); while (!s_ready);
        updates_sb.note_path(flow, cost, eog, eor);
    endtask

    task automatic push_group(input int paths, input bit close_round);
        bit eog;
        for (int k = 0; k < paths; k++) begin
            eog = (k == paths - 1);
            push_path(draw_flow(), draw_cost(), eog,
                      eog ? close_round : ($urandom_range(0, 7) == 0), draw_gap());
        end
    endtask

    task automatic run_random_phase(input int beats);
        int sent;
        int paths;
        sent = 0;
        while (sent < beats) begin
            case ($urandom_range(0, 19))
                0: paths = $urandom_range(psfu_pkg::MAX_PATHS + 1, psfu_pkg::MAX_PATHS + 3);
                1, 2: paths = $urandom_range(7, psfu_pkg::MAX_PATHS);
                default: paths = $urandom_range(1, 6);
            endcase
            steady = ($urandom_range(0, 4) == 0);
            push_group(paths, $urandom_range(0, 2) == 0);
            sent += paths;
        end
    endtask

    task automatic drain_updates();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (updates_sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_step(input logic [psfu_pkg::STEP_W-1:0] value);
        drain_updates();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        updates_sb.step_q16 = value;
    endtask

    initial begin : result_sink
        path_update_t seen;
        int           stall;
        @(posedge aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            seen.new_flow      = m_new_flow;
            seen.flow_change   = m_flow_change;
            seen.last_of_group = m_last_of_group;
            seen.total_change  = m_total_change;
            updates_sb.check_result(seen);
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single path, no change
        push_path(psfu_pkg::FLOW_MAX, 32'h8000_0000, 1'b1, 1'b0, draw_gap());
        // extreme costs, both directions saturate
        push_path(psfu_pkg::FLOW_MAX, 32'h7FFF_FFFF, 1'b0, 1'b0, draw_gap());
        push_path(psfu_pkg::FLOW_MAX, 32'h8000_0000, 1'b1, 1'b0, draw_gap());
        push_path(psfu_pkg::FLOW_W'(32'h0001_0000), 32'h0001_0000, 1'b0, 1'b0, draw_gap());
        push_path(psfu_pkg::FLOW_W'(32'h0002_0000), 32'h0003_0000, 1'b1, 1'b0, draw_gap());
        // equal costs, round mark only counts on the group end
        for (int k = 0; k < 3; k++) begin
            push_path(draw_flow(), 32'h0001_0000, k == 2, 1'b1, draw_gap());
        end
        // overflow, closing beat is dropped but still ends the group
        for (int k = 0; k <= psfu_pkg::MAX_PATHS; k++) begin
            push_path(draw_flow(), draw_cost(), k == psfu_pkg::MAX_PATHS,
                      k == psfu_pkg::MAX_PATHS, draw_gap());
        end

        step_plan[3] = psfu_pkg::STEP_W'($urandom);
        foreach (step_plan[p]) begin
            load_step(step_plan[p]);
            run_random_phase(PHASE_BEATS);
        end

        drain_updates();
        if (updates_sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### files.f
design/psfu_pkg.sv
design/psfu_ram.sv
design/psfu_ctrl.sv
design/psfu_dp.sv
design/proportional_switch_flow_update.sv
dv/testbench.sv
